// ----- rtl/core/rgb2hsl_pkg.sv -----
// Shared constants for the RGB to HSL converter.
`timescale 1ns / 1ps

package rgb2hsl_pkg;

	// Hue scale: one sector of 60 degrees in 1/64 degree, and the full circle.
	localparam int unsigned HUE_SECTOR = 3840;
	localparam int unsigned HUE_FULL   = 23040;

	// Shared divider geometry: numerator, divisor and quotient widths.
	localparam int unsigned DIV_NW = 25;
	localparam int unsigned DIV_DW = 9;
	localparam int unsigned DIV_QW = 16;

endpackage

// ----- rtl/core/rgb_to_hsl_converter.sv -----
// Top level: streaming RGB to HSL converter.
`timescale 1ns / 1ps

// Converts one 8-bit RGB pixel per word into hue (1/64 degree, 0..23039),
// saturation and lightness (16-bit fractions, 65535 = 1.0), all rounded to
// nearest; grey pixels give hue 0 and saturation 0. One word is accepted
// every clock unless held; four stages of min/max, sector and numerator
// work, sixteen stages of the two bit-per-stage dividers and the output
// register make up the pipeline, which holds while a result waits on tready.

module rgb_to_hsl_converter
	import rgb2hsl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata    // hue[14:0], saturation[30:15], lightness[46:31], 0
);

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	logic adv;
	assign adv           = ~m_axis_tvalid | m_axis_tready;
	assign s_axis_tready = adv;

	// Stage 1: input register
	logic       vld_s1;
	logic [7:0] r_s1, g_s1, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1 <= s_axis_tdata[7:0];
			g_s1 <= s_axis_tdata[15:8];
			b_s1 <= s_axis_tdata[23:16];
		end
	end

	// Max, min and sector; ties go red, then green
	logic       red_max, green_max;
	logic [7:0] mx, mn, mn_rg;
	sector_t    sec;
	logic [7:0] da, db;

	always_comb begin
		red_max   = (r_s1 >= g_s1) && (r_s1 >= b_s1);
		green_max = !red_max && (g_s1 >= b_s1);
		mn_rg     = (g_s1 < r_s1) ? g_s1 : r_s1;
		mn        = (b_s1 < mn_rg) ? b_s1 : mn_rg;
		if (red_max) begin
			sec = SEC_RED;
			mx  = r_s1;
			da  = g_s1;
			db  = b_s1;
		end else if (green_max) begin
			sec = SEC_GREEN;
			mx  = g_s1;
			da  = b_s1;
			db  = r_s1;
		end else begin
			sec = SEC_BLUE;
			mx  = b_s1;
			da  = r_s1;
			db  = g_s1;
		end
	end

	// Stage 2
	logic       vld_s2;
	logic [7:0] mx_s2, mn_s2, da_s2, db_s2;
	sector_t    sec_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s2  <= mx;
			mn_s2  <= mn;
			da_s2  <= da;
			db_s2  <= db;
			sec_s2 <= sec;
		end
	end

	logic [7:0]  d, den, absdiff;
	logic [8:0]  sum, diff;
	logic [16:0] light17;
	logic        neg;

	always_comb begin
		d       = mx_s2 - mn_s2;
		sum     = {1'b0, mx_s2} + {1'b0, mn_s2};
		den     = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
		light17 = {sum, 8'd0} + 17'(sum) + 17'd1;
		diff    = {1'b0, da_s2} - {1'b0, db_s2};
		neg     = diff[8];
		absdiff = neg ? 8'(-diff) : diff[7:0];
	end

	// Stage 3
	logic        vld_s3, neg_s3;
	logic [7:0]  d_s3, den_s3, absdiff_s3;
	logic [15:0] light_s3;
	sector_t     sec_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s3       <= d;
			den_s3     <= den;
			absdiff_s3 <= absdiff;
			neg_s3     <= neg;
			light_s3   <= light17[16:1];
			sec_s3     <= sec_s2;
		end
	end

	logic [14:0] factor;
	logic [22:0] off;
	logic [19:0] sd;
	logic [7:0]  d_eff, den_eff;
	logic [24:0] sat_n;

	always_comb begin
		case (sec_s3)
			SEC_RED:   factor = neg_s3 ? 15'(HUE_FULL) : 15'd0;
			SEC_GREEN: factor = 15'(2 * HUE_SECTOR);
			SEC_BLUE:  factor = 15'(4 * HUE_SECTOR);
			default:   factor = 15'd0;
		endcase
		off     = 23'(factor) * 23'(d_s3);
		sd      = 20'(absdiff_s3) * 20'(HUE_SECTOR);
		// grey: force divisors to 1, numerators then give zero quotients
		d_eff   = (d_s3 == 8'd0) ? 8'd1 : d_s3;
		den_eff = (den_s3 == 8'd0) ? 8'd1 : den_s3;
		// 2 * 65535 * d + den
		sat_n   = {d_s3, 17'd0} - {16'd0, d_s3, 1'b0} + 25'(den_eff);
	end

	// Stage 4
	logic        vld_s4, neg_s4;
	logic [22:0] off_s4;
	logic [19:0] sd_s4;
	logic [7:0]  d_eff_s4, den_eff_s4;
	logic [24:0] sat_n_s4;
	logic [15:0] light_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			off_s4     <= off;
			sd_s4      <= sd;
			neg_s4     <= neg_s3;
			d_eff_s4   <= d_eff;
			den_eff_s4 <= den_eff;
			sat_n_s4   <= sat_n;
			light_s4   <= light_s3;
		end
	end

	logic [22:0]       num;
	logic [DIV_NW-1:0] hue_n;

	always_comb begin
		num   = neg_s4 ? (off_s4 - 23'(sd_s4)) : (off_s4 + 23'(sd_s4));
		hue_n = DIV_NW'({num, 1'b0}) + DIV_NW'(d_eff_s4);
	end

	// Dividers: round(n/d) as floor((2n + d) / 2d)
	logic [DIV_QW-1:0] hue_q, sat_q;

	rgb2hsl_div #(
		.NW(DIV_NW),
		.DW(DIV_DW),
		.QW(DIV_QW)
	) u_hue_div (
		.clk (clk),
		.en  (adv),
		.n_in(hue_n),
		.d_in({d_eff_s4, 1'b0}),
		.q   (hue_q)
	);

	rgb2hsl_div #(
		.NW(DIV_NW),
		.DW(DIV_DW),
		.QW(DIV_QW)
	) u_sat_div (
		.clk (clk),
		.en  (adv),
		.n_in(sat_n_s4),
		.d_in({den_eff_s4, 1'b0}),
		.q   (sat_q)
	);

	// Valid and lightness ride alongside the divider stages
	logic        vld_d_s [DIV_QW];
	logic [15:0] light_d_s [DIV_QW];

	for (genvar k = 0; k < DIV_QW; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_d_s[k] <= 1'b0;
			end else if (adv) begin
				vld_d_s[k] <= (k == 0) ? vld_s4 : vld_d_s[(k == 0) ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				light_d_s[k] <= (k == 0) ? light_s4 : light_d_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	// Wrap a rounded full circle back to zero
	logic [14:0] hue_w;
	assign hue_w = (hue_q >= DIV_QW'(HUE_FULL)) ? 15'(hue_q - DIV_QW'(HUE_FULL))
		: hue_q[14:0];

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			m_axis_tvalid <= vld_d_s[DIV_QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_axis_tdata <= {1'b0, light_d_s[DIV_QW-1], sat_q, hue_w};
		end
	end

endmodule

// ----- rtl/core/rgb2hsl_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, quotient known to fit QW bits.
`timescale 1ns / 1ps

module rgb2hsl_div
	import rgb2hsl_pkg::*;
#(
	parameter int unsigned NW = DIV_NW,
	parameter int unsigned DW = DIV_DW,
	parameter int unsigned QW = DIV_QW
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] n_in,
	input  logic [DW-1:0] d_in,
	output logic [QW-1:0] q
);

	// High part of the numerator is below the divisor, so it seeds the remainder.
	logic [DW-1:0] rem_s  [QW];
	logic [QW-1:0] word_s [QW];
	logic [DW-1:0] den_s  [QW];

	logic [DW-1:0] rem_in  [QW];
	logic [QW-1:0] word_in [QW];
	logic [DW-1:0] den_in  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW:0] trial;
		logic        ge;

		if (k == 0) begin : g_first
			assign rem_in[k]  = DW'(n_in[NW-1:QW]);
			assign word_in[k] = n_in[QW-1:0];
			assign den_in[k]  = d_in;
		end else begin : g_next
			assign rem_in[k]  = rem_s[k-1];
			assign word_in[k] = word_s[k-1];
			assign den_in[k]  = den_s[k-1];
		end

		assign trial = {rem_in[k], word_in[k][QW-1]};
		assign ge    = (trial >= {1'b0, den_in[k]});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? DW'(trial - {1'b0, den_in[k]}) : DW'(trial);
				word_s[k] <= {word_in[k][QW-2:0], ge};
				den_s[k]  <= den_in[k];
			end
		end
	end

	assign q = word_s[QW-1];

endmodule
